// ===== src/cls_pkg.sv =====
// Shared types and codes for the circular list store.
package cls_pkg;

    localparam int POS_W     = 10;
    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 5;
    localparam int BIT_IDX_W = $clog2(POS_W);

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_WALK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic rotate;
        logic drop;
        logic wen;
    } cell_ctrl_t;

endpackage

// ===== src/cls_cell.sv =====
// One storage cell of the entry ring.
module cls_cell
    import cls_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]         len,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic signed [DATA_W-1:0] head_data,
    input  logic signed [DATA_W-1:0] next_data,
    output logic signed [DATA_W-1:0] data
);

    localparam logic [CNT_W-1:0] IDX_V  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] LAST_V = CNT_W'(IDX + 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     is_last;
    logic                     in_ring;
    logic                     before_last;

    assign is_last     = (len == LAST_V);
    assign in_ring     = (IDX_V < len);
    assign before_last = (LAST_V < len);

    always_comb begin
        data_next = data_reg;
        if (ctrl.wen && (len == IDX_V)) begin
            data_next = wdata;
        end else if (ctrl.rotate && in_ring) begin
            data_next = is_last ? head_data : next_data;
        end else if (ctrl.drop && before_last) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/cls_mod_unit.sv =====
// Restoring remainder unit: position modulo count, one bit per cycle.
module cls_mod_unit
    import cls_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [POS_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W:0]       shifted;

    assign shifted = {rem_reg, dvd_reg[POS_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            bit_next  = BIT_IDX_W'(POS_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = CNT_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = CNT_W'(shifted);
            end
            if (bit_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                bit_next = bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bit_reg <= bit_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/circular_list_store_core.sv =====
// Top level of the circular list store: command sequencer over a ring of cells.
//
// Ordered store of up to CAPACITY signed 32-bit entries, head first, held in a
// ring of cells. Append, an unused command and any full or empty case go
// straight to the result state. Read and remove first run the
// position-modulo-count unit (one bit of the 10-bit position per cycle), then
// one ring rotation per stored entry while the addressed entry passes the
// head cell, where it is captured and, for remove, dropped. The next
// command is accepted while a finished result waits on the output.
module circular_list_store_core
    import cls_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_command,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [POS_W-1:0]         s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_data,
    output logic [OUT_CNT_W-1:0]     m_count,
    output logic [1:0]               m_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         walk_len_reg, walk_len_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]         slot_reg, slot_next;
    logic                     remove_reg, remove_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_read_data_reg, m_read_data_next;
    logic [OUT_CNT_W-1:0]     m_count_reg, m_count_next;
    logic [1:0]               m_status_reg, m_status_next;

    logic                     accept;
    logic                     div_start;
    logic                     div_done;
    logic [CNT_W-1:0]         div_rem;
    logic                     at_slot;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign at_slot = (step_reg == slot_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        walk_len_next    = walk_len_reg;
        step_next        = step_reg;
        slot_next        = slot_reg;
        remove_next      = remove_reg;
        res_data_next    = res_data_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_read_data_next = m_read_data_reg;
        m_count_next     = m_count_reg;
        m_status_next    = m_status_reg;
        div_start        = 1'b0;
        ctrl             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_data_next   = '0;
                    res_status_next = STAT_OK;
                    state_next      = S_FINISH;
                    unique case (s_command) inside
                        CMD_APPEND: begin
                            if (count_reg == CAP_V) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ctrl.wen   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_READ: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                div_start     = 1'b1;
                                walk_len_next = count_reg;
                                remove_next   = (s_command == CMD_REMOVE);
                                state_next    = S_DIVIDE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIVIDE: begin
                if (div_done) begin
                    slot_next  = div_rem;
                    step_next  = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (at_slot) begin
                    res_data_next = cell_data[0];
                end
                if (at_slot && remove_reg) begin
                    ctrl.drop  = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    ctrl.rotate = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == walk_len_reg - 1'b1) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_read_data_next = res_data_reg;
                    m_count_next     = OUT_CNT_W'(count_reg);
                    m_status_next    = res_status_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        walk_len_reg    <= walk_len_next;
        step_reg        <= step_next;
        slot_reg        <= slot_next;
        remove_reg      <= remove_next;
        res_data_reg    <= res_data_next;
        res_status_reg  <= res_status_next;
        m_read_data_reg <= m_read_data_next;
        m_count_reg     <= m_count_next;
        m_status_reg    <= m_status_next;
    end

    cls_mod_unit #(
        .CNT_W(CNT_W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_position),
        .divisor  (count_reg),
        .done     (div_done),
        .remainder(div_rem)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] next_data;
        if (i == CAPACITY - 1) begin : g_end
            assign next_data = cell_data[0];
        end else begin : g_mid
            assign next_data = cell_data[i+1];
        end
        cls_cell #(
            .CNT_W(CNT_W),
            .IDX  (i)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .len      (count_reg),
            .wdata    (s_value),
            .head_data(cell_data[0]),
            .next_data(next_data),
            .data     (cell_data[i])
        );
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_count     = m_count_reg;
    assign m_status    = m_status_reg;

endmodule

// ===== tb/circular_list_store_core_test.sv =====
// Self-checking testbench for circular_list_store_core: mirrored list, random handshakes.
`timescale 1ns / 100ps

module circular_list_store_core_test;
    import cls_pkg::*;

    localparam int          CAP         = 16;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          RANDOM_CMDS = 1250;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [OUT_CNT_W-1:0]     count;
        logic [1:0]               status;
    } reply_t;

    class list_store_mirror;
        logic signed [DATA_W-1:0] cells [CAP];
        int unsigned              fill;
        reply_t                   expected_replies [$];
        int unsigned              errors;
        int unsigned              replies_seen;
        int unsigned              full_hits;
        int unsigned              empty_hits;
        int unsigned              wrap_hits;
        int unsigned              removes_done;
        int unsigned              reads_done;

        function new();
            fill = 0;
            errors = 0;
            replies_seen = 0;
            full_hits = 0;
            empty_hits = 0;
            wrap_hits = 0;
            removes_done = 0;
            reads_done = 0;
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        function void note_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
                                   input logic [POS_W-1:0] pos);
            reply_t      r;
            int unsigned slot;
            r.data = '0;
            r.status = STAT_OK;
            case (cmd) inside
                CMD_APPEND: begin
                    if (fill >= CAP) begin
                        r.status = STAT_FULL;
                        full_hits++;
                    end else begin
                        cells[fill] = val;
                        fill++;
                    end
                end
                CMD_REMOVE, CMD_READ: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                        empty_hits++;
                    end else begin
                        if (pos >= fill) wrap_hits++;
                        slot = pos % fill;
                        r.data = cells[slot];
                        if (cmd == CMD_REMOVE) begin
                            for (int i = slot; i + 1 < fill; i++) cells[i] = cells[i + 1];
                            fill--;
                            removes_done++;
                        end else begin
                            reads_done++;
                        end
                    end
                end
                default: ;
            endcase
            r.count = OUT_CNT_W'(fill);
            expected_replies.push_back(r);
        endfunction

        function void report(input string field, input longint exp_v, input longint act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        endfunction

        function void check_reply(input logic signed [DATA_W-1:0] data,
                                  input logic [OUT_CNT_W-1:0] count, input logic [1:0] status);
            reply_t r;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                errors++;
                $display({"%0t: unexpected transaction, expected none, ",
                          "actual data %0d count %0d status %0d"},
                         $time, data, count, status);
                return;
            end
            r = expected_replies.pop_front();
            if (data !== r.data) report("read_data", r.data, data);
            if (count !== r.count) report("count", r.count, count);
            if (status !== r.status) report("status", r.status, status);
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_command;
    logic signed [DATA_W-1:0] s_value;
    logic [POS_W-1:0]         s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_read_data;
    logic [OUT_CNT_W-1:0]     m_count;
    logic [1:0]               m_status;

    list_store_mirror store = new();

    circular_list_store_core #(.CAPACITY(CAP)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_value     (s_value),
        .s_position  (s_position),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_count     (m_count),
        .m_status    (m_status)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_value <= val;
        s_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        store.note_command(cmd, val, pos);
    endtask

    task automatic hold_off(input int unsigned cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (store.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        case (sel) inside
            0, 1:    return POS_W'($urandom);
            2:       return POS_W'($urandom_range(0, store.fill + 1));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '1;
                    1:       return '0;
                    2:       return POS_W'(store.fill);
                    default: return POS_W'(512);
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '1;
            3:       return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Receiver: sample the result at the edge, then pick the next ready level.
    initial begin
        int unsigned tick;
        int unsigned pattern;
        tick = 0;
        pattern = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                store.check_reply(m_read_data, m_count, m_status);
            tick++;
            if (tick % 80 == 0) pattern = $urandom_range(0, 3);
            case (pattern)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((tick % 14) >= 11);
            endcase
        end
    end

    initial begin
        int unsigned burst_left;
        int unsigned mode;
        int unsigned roll;
        int unsigned guard;
        logic [1:0]  cmd;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_command <= CMD_APPEND;
        s_value <= '0;
        s_position <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty cases, extremes, wrap, only-entry removal, full store.
        send_command(CMD_READ, 0, 0);
        send_command(CMD_REMOVE, 0, '1);
        send_command(CMD_UNUSED, '1, '1);
        send_command(CMD_APPEND, 32'sh7FFF_FFFF, '1);
        send_command(CMD_APPEND, 32'sh8000_0000, 0);
        send_command(CMD_READ, 0, '1);
        send_command(CMD_READ, 0, 2);
        send_command(CMD_REMOVE, 0, 1);
        send_command(CMD_REMOVE, 0, 5);
        send_command(CMD_READ, '1, 3);
        for (int i = 0; i < CAP; i++)
            send_command(CMD_APPEND, (i % 2) ? ~(32'sd1 <<< i) : (32'sd1 <<< (2 * i)), POS_W'(i));
        send_command(CMD_APPEND, 32'sh1234_5678, 0);
        send_command(CMD_READ, 0, POS_W'(CAP));
        send_command(CMD_READ, 0, POS_W'(CAP - 1));
        send_command(CMD_REMOVE, 0, '1);
        send_command(CMD_UNUSED, 0, 0);
        drain_replies();

        burst_left = 0;
        mode = 2;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (burst_left == 0) begin
                hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 3) == 0) mode = $urandom_range(0, 2);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = CMD_UNUSED;
            end else begin
                case (mode)
                    0:       cmd = (roll < 70) ? CMD_APPEND : (roll < 85) ? CMD_REMOVE : CMD_READ;
                    1:       cmd = (roll < 25) ? CMD_APPEND : (roll < 70) ? CMD_REMOVE : CMD_READ;
                    default: cmd = (roll < 45) ? CMD_APPEND : (roll < 70) ? CMD_REMOVE : CMD_READ;
                endcase
            end
            send_command(cmd, pick_value(), pick_position());
            if (n % 300 == 299) begin
                drain_replies();
                burst_left = 0;
            end
        end

        s_valid <= 1'b0;
        guard = 0;
        while (store.pending() != 0 && guard < 100_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4 * CAP) @(posedge aclk);

        $display("Covered %0d results: %0d reads, %0d removes, %0d wrapped positions",
                 store.replies_seen, store.reads_done, store.removes_done, store.wrap_hits);
        $display("Full-store appends %0d, empty-store requests %0d, mismatches %0d, left over %0d",
                 store.full_hits, store.empty_hits, store.errors, store.pending());
        if (store.errors == 0 && store.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/cls_pkg.sv
src/cls_cell.sv
src/cls_mod_unit.sv
src/circular_list_store_core.sv
tb/circular_list_store_core_test.sv
